/* rtl/hpdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpdc_pkg
// Shared types, constants and command codes of the heading PID drive controller.
// ----------------------------------------------------------------------------
package hpdc_pkg;

   localparam int DEF_VALUE_WIDTH = 16;
   localparam int DEF_SUM_WIDTH   = 32;

   // field widths
   localparam int YAW_W      = 16;
   localparam int ERR_W      = 17;   // raw yaw difference
   localparam int WRAP_W     = 15;
   localparam int VEL_W      = 16;
   localparam int GAIN_W     = 16;
   localparam int SPEED_W    = 15;
   localparam int THRESH_W   = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 1;

   // arithmetic
   localparam int MUL_W      = 18;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int CHUNK_W    = 16;
   localparam int FRAC_SHIFT = 8;
   localparam int OFS_SHIFT  = 16;
   localparam int DIVIDEND_W = 30;
   localparam int QUOT_W     = 15;
   localparam int DIVISOR_W  = 17;
   localparam int DIV_STEPS  = QUOT_W;
   localparam int CNT_W      = 4;

   localparam logic signed [ERR_W-1:0] PI_Q12     = 17'sd12868;
   localparam logic signed [ERR_W-1:0] NEG_PI_Q12 = -17'sd12868;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q12 = 17'sd25736;
   localparam logic [GAIN_W-1:0]       HALF_TRACK_Q16 = 16'd12452;
   localparam logic [DIVIDEND_W-1:0]   ROUND_HALF = 30'd32768;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ANGULAR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGNED_THR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGNED_SPEED = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TURNING_SPEED = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_LIMIT   = 3'd7;

   typedef struct packed {
      logic [GAIN_W-1:0]   prop_gain;
      logic [GAIN_W-1:0]   integral_gain;
      logic [GAIN_W-1:0]   deriv_gain;
      logic [SPEED_W-1:0]  max_angular;
      logic [THRESH_W-1:0] aligned_threshold;
      logic [SPEED_W-1:0]  aligned_speed;
      logic [SPEED_W-1:0]  turning_speed;
      logic [SPEED_W-1:0]  wheel_speed_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prop_gain:         16'd307,
      integral_gain:     16'd66,
      deriv_gain:        16'd512,
      max_angular:       15'd3277,
      aligned_threshold: 14'd1024,
      aligned_speed:     15'd1638,
      turning_speed:     15'd205,
      wheel_speed_limit: 15'd2048
   };

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_WRAP,
      OP_UPDATE,
      OP_MUL_D,
      OP_I_HEAD,
      OP_I_NEXT,
      OP_I_TAIL,
      OP_SUM,
      OP_CLAMP,
      OP_OFS,
      OP_PEAK,
      OP_MUL_LIN,
      OP_MUL_ANG,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_OUT
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WRAP,
      S_UPDATE,
      S_MUL_D,
      S_I_HEAD,
      S_I_NEXT,
      S_I_TAIL,
      S_SUM,
      S_CLAMP,
      S_OFS,
      S_PEAK,
      S_MUL_LIN,
      S_MUL_ANG,
      S_DIV_LOAD,
      S_DIV,
      S_FINISH
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic wrap_done;
      logic stopped;
      logic limit_hit;
   } status_type;

endpackage

/* rtl/hpdc_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpdc_divider
// Restoring divider, one quotient bit per step. The caller guarantees the
// upper dividend bits are below the divisor, so QUOT_W steps suffice.
// ----------------------------------------------------------------------------
module hpdc_divider (
   input  logic                             clock,
   input  logic                             load,
   input  logic                             step,
   input  logic [hpdc_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [hpdc_pkg::DIVISOR_W-1:0]   divisor,
   output logic [hpdc_pkg::QUOT_W-1:0]      quotient
);
   import hpdc_pkg::*;

   logic [DIVISOR_W-1:0] rem_ff;
   logic [QUOT_W-1:0]    quo_ff;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   trial;

   assign shifted = {rem_ff, quo_ff[QUOT_W-1]};
   assign trial   = shifted - (DIVISOR_W + 1)'(divisor);

   // quo_ff starts with the low dividend bits and fills with quotient bits
   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
         quo_ff <= dividend[QUOT_W-1:0];
      end else if (step) begin
         if (shifted >= (DIVISOR_W + 1)'(divisor)) begin
            rem_ff <= trial[DIVISOR_W-1:0];
            quo_ff <= {quo_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DIVISOR_W-1:0];
            quo_ff <= {quo_ff[QUOT_W-2:0], 1'b0};
         end
      end
   end

   assign quotient = quo_ff;

endmodule

/* rtl/hpdc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpdc_datapath
// Error wrap, PID state, shared 18x18 multiplier, speed selection, wheel
// limit scaling through two serial dividers, and the result register.
// ----------------------------------------------------------------------------
module hpdc_datapath #(
   parameter int VALUE_WIDTH = hpdc_pkg::DEF_VALUE_WIDTH,
   parameter int SUM_WIDTH   = hpdc_pkg::DEF_SUM_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hpdc_pkg::cmd_type                cmd,
   output hpdc_pkg::status_type             status,
   input  hpdc_pkg::cfg_type                cfg,
   input  logic [hpdc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [hpdc_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic [hpdc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [hpdc_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import hpdc_pkg::*;

   localparam int ES_CHUNKS = (SUM_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int ES_EXT_W  = ES_CHUNKS * CHUNK_W;
   localparam int IACC_W    = ES_EXT_W + MUL_W + 2;
   localparam int ACC_W     = IACC_W + 1;
   localparam int SH_W      = ACC_W - FRAC_SHIFT;
   localparam int SAT_W     = (VALUE_WIDTH > ERR_W) ? VALUE_WIDTH : ERR_W;

   // ---- registers ----
   logic signed [ERR_W-1:0]       err_ff;
   logic                          stop_ff;
   logic signed [SUM_WIDTH-1:0]   es_ff;
   logic signed [VALUE_WIDTH-1:0] le_ff;
   logic signed [ERR_W-1:0]       deriv_ff;
   logic [ES_EXT_W-1:0]           es_sh_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [IACC_W-1:0]      iacc_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [VEL_W-1:0]       ang_ff;
   logic [VEL_W-1:0]              absang_ff;
   logic [SPEED_W-1:0]            lin_ff;
   logic [DIVISOR_W-1:0]          peak_ff;
   logic                          lim_ff;
   logic [DIVIDEND_W-1:0]         linprod_ff;
   logic [RSP_DATA_W-1:0]         rsp_data_ff;
   logic [RSP_USER_W-1:0]         rsp_user_ff;

   // ---- combinational ----
   logic signed [YAW_W-1:0]       robot_yaw;
   logic signed [YAW_W-1:0]       target_yaw;
   logic signed [ERR_W-1:0]       yaw_diff;
   logic signed [SUM_WIDTH:0]     es_wide;
   logic signed [SUM_WIDTH-1:0]   es_new;
   logic signed [SAT_W-1:0]       err_x;
   logic signed [SAT_W-1:0]       le_max;
   logic signed [SAT_W-1:0]       le_min;
   logic signed [VALUE_WIDTH-1:0] le_new;
   logic signed [ERR_W:0]         deriv_wide;
   logic signed [MUL_W-1:0]       mul_a;
   logic signed [MUL_W-1:0]       mul_b;
   logic signed [PROD_W-1:0]      mul_p;
   logic                          mul_en;
   logic [CHUNK_W-1:0]            es_top;
   logic signed [IACC_W-1:0]      iacc_next;
   logic signed [SH_W-1:0]        ang_raw;
   logic signed [SH_W-1:0]        max_s;
   logic signed [VEL_W-1:0]       ang_clamp;
   logic [VEL_W-1:0]              absang_clamp;
   logic [ERR_W-1:0]              err_abs;
   logic [DIVIDEND_W-1:0]         ofs_sum;
   logic [DIVISOR_W-1:0]          peak;
   logic                          limit_hit;
   logic [QUOT_W-1:0]             q_lin;
   logic [QUOT_W-1:0]             q_ang;
   logic signed [VEL_W-1:0]       lin_out;
   logic signed [VEL_W-1:0]       ang_out;
   logic                          div_load;
   logic                          div_step;

   assign robot_yaw  = signed'(req_tdata[YAW_W-1:0]);
   assign target_yaw = signed'(req_tdata[2*YAW_W-1:YAW_W]);
   assign yaw_diff   = ERR_W'(target_yaw) - ERR_W'(robot_yaw);

   // saturating error sum
   assign es_wide = (SUM_WIDTH + 1)'(es_ff) + (SUM_WIDTH + 1)'(err_ff);
   always_comb begin
      if (es_wide[SUM_WIDTH] != es_wide[SUM_WIDTH-1]) begin
         es_new = es_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                     : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         es_new = es_wide[SUM_WIDTH-1:0];
      end
   end

   // last error saturated to VALUE_WIDTH
   assign err_x  = SAT_W'(err_ff);
   assign le_max = SAT_W'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
   assign le_min = ~le_max;
   always_comb begin
      if (err_x > le_max) begin
         le_new = VALUE_WIDTH'(le_max);
      end else if (err_x < le_min) begin
         le_new = VALUE_WIDTH'(le_min);
      end else begin
         le_new = VALUE_WIDTH'(err_x);
      end
   end

   // last_error always comes from a wrapped error, so 18 bits hold it
   assign deriv_wide = (ERR_W + 1)'(err_ff) - (ERR_W + 1)'(le_ff);

   assign es_top = es_sh_ff[ES_EXT_W-1 -: CHUNK_W];

   // shared multiplier operand select
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b0;
      case (cmd.op)
         OP_UPDATE: begin
            mul_a  = MUL_W'(cfg.prop_gain);
            mul_b  = MUL_W'(err_ff);
            mul_en = 1'b1;
         end
         OP_MUL_D: begin
            mul_a  = MUL_W'(cfg.deriv_gain);
            mul_b  = MUL_W'(deriv_ff);
            mul_en = 1'b1;
         end
         OP_I_HEAD: begin
            mul_a  = MUL_W'(cfg.integral_gain);
            mul_b  = MUL_W'(signed'(es_top));
            mul_en = 1'b1;
         end
         OP_I_NEXT: begin
            mul_a  = MUL_W'(cfg.integral_gain);
            mul_b  = {2'b00, es_top};
            mul_en = 1'b1;
         end
         OP_OFS: begin
            mul_a  = MUL_W'(HALF_TRACK_Q16);
            mul_b  = MUL_W'(absang_ff);
            mul_en = 1'b1;
         end
         OP_MUL_LIN: begin
            mul_a  = MUL_W'(cfg.wheel_speed_limit);
            mul_b  = MUL_W'(lin_ff);
            mul_en = 1'b1;
         end
         OP_MUL_ANG: begin
            mul_a  = MUL_W'(cfg.wheel_speed_limit);
            mul_b  = MUL_W'(absang_ff);
            mul_en = 1'b1;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign mul_p     = mul_a * mul_b;
   assign iacc_next = (iacc_ff <<< CHUNK_W) + IACC_W'(prod_ff);

   // angular clamp and speed selection
   assign ang_raw = signed'(acc_ff[ACC_W-1:FRAC_SHIFT]);
   assign max_s   = SH_W'(cfg.max_angular);
   always_comb begin
      if (ang_raw > max_s) begin
         ang_clamp    = VEL_W'(cfg.max_angular);
         absang_clamp = VEL_W'(cfg.max_angular);
      end else if (ang_raw < -max_s) begin
         ang_clamp    = -VEL_W'(cfg.max_angular);
         absang_clamp = VEL_W'(cfg.max_angular);
      end else begin
         ang_clamp    = VEL_W'(ang_raw);
         absang_clamp = ang_raw[SH_W-1] ? VEL_W'(-ang_raw) : VEL_W'(ang_raw);
      end
   end
   assign err_abs = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);

   // wheel offset rounded half up, then peak wheel speed
   assign ofs_sum   = prod_ff[DIVIDEND_W-1:0] + ROUND_HALF;
   assign peak      = DIVISOR_W'(lin_ff) + DIVISOR_W'(ofs_sum[DIVIDEND_W-1:OFS_SHIFT]);
   assign limit_hit = (cfg.wheel_speed_limit != '0)
                      && (peak > DIVISOR_W'(cfg.wheel_speed_limit));

   assign div_load = (cmd.op == OP_DIV_LOAD);
   assign div_step = (cmd.op == OP_DIV_STEP);

   hpdc_divider u_div_lin (
      .clock    (clock),
      .load     (div_load),
      .step     (div_step),
      .dividend (linprod_ff),
      .divisor  (peak_ff),
      .quotient (q_lin)
   );

   hpdc_divider u_div_ang (
      .clock    (clock),
      .load     (div_load),
      .step     (div_step),
      .dividend (prod_ff[DIVIDEND_W-1:0]),
      .divisor  (peak_ff),
      .quotient (q_ang)
   );

   assign lin_out = lim_ff ? VEL_W'(q_lin) : VEL_W'(lin_ff);
   always_comb begin
      if (!lim_ff) begin
         ang_out = ang_ff;
      end else if (ang_ff[VEL_W-1]) begin
         ang_out = -VEL_W'(q_ang);
      end else begin
         ang_out = VEL_W'(q_ang);
      end
   end

   // ---- PID state, changed only for live items ----
   always_ff @(posedge clock) begin
      if (reset) begin
         es_ff <= '0;
         le_ff <= '0;
      end else if (cmd.op == OP_UPDATE) begin
         es_ff <= es_new;
         le_ff <= le_new;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_p;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            err_ff  <= yaw_diff;
            stop_ff <= !(req_tuser[0] && req_tuser[1]);
         end
         OP_WRAP: begin
            if (err_ff > PI_Q12) begin
               err_ff <= err_ff - TWO_PI_Q12;
            end else if (err_ff <= NEG_PI_Q12) begin
               err_ff <= err_ff + TWO_PI_Q12;
            end
         end
         OP_UPDATE: begin
            deriv_ff <= ERR_W'(deriv_wide);
            es_sh_ff <= ES_EXT_W'(es_new);
         end
         OP_MUL_D: begin
            acc_ff <= ACC_W'(prod_ff);
         end
         OP_I_HEAD: begin
            acc_ff   <= acc_ff + ACC_W'(prod_ff);
            iacc_ff  <= '0;
            es_sh_ff <= es_sh_ff << CHUNK_W;
         end
         OP_I_NEXT: begin
            iacc_ff  <= iacc_next;
            es_sh_ff <= es_sh_ff << CHUNK_W;
         end
         OP_I_TAIL: begin
            iacc_ff <= iacc_next;
         end
         OP_SUM: begin
            acc_ff <= acc_ff + ACC_W'(iacc_ff >>> FRAC_SHIFT);
         end
         OP_CLAMP: begin
            ang_ff    <= ang_clamp;
            absang_ff <= absang_clamp;
            lin_ff    <= (err_abs < ERR_W'(cfg.aligned_threshold)) ? cfg.aligned_speed
                                                                    : cfg.turning_speed;
         end
         OP_PEAK: begin
            peak_ff <= peak;
            lim_ff  <= limit_hit;
         end
         OP_MUL_ANG: begin
            linprod_ff <= prod_ff[DIVIDEND_W-1:0];
         end
         OP_OUT: begin
            if (stop_ff) begin
               rsp_data_ff <= '0;
               rsp_user_ff <= '0;
            end else begin
               rsp_data_ff <= {1'b0, err_ff[WRAP_W-1:0], ang_out, lin_out};
               rsp_user_ff <= lim_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign status.wrap_done = (err_ff <= PI_Q12) && (err_ff > NEG_PI_Q12);
   assign status.stopped   = stop_ff;
   assign status.limit_hit = limit_hit;

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

/* rtl/hpdc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpdc_ctrl
// Sequencer: steps the datapath through one tick and owns both handshakes.
// ----------------------------------------------------------------------------
module hpdc_ctrl #(
   parameter int SUM_WIDTH = hpdc_pkg::DEF_SUM_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output hpdc_pkg::cmd_type    cmd,
   input  hpdc_pkg::status_type status
);
   import hpdc_pkg::*;

   localparam int I_CHUNKS = (SUM_WIDTH + CHUNK_W - 1) / CHUNK_W;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_load;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_WRAP;
            end
         end
         S_WRAP: begin
            if (status.stopped) begin
               state_in = S_FINISH;
            end else if (status.wrap_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: state_in = S_MUL_D;
         S_MUL_D:  state_in = S_I_HEAD;
         S_I_HEAD: begin
            cnt_in   = CNT_W'(1);
            state_in = (I_CHUNKS > 1) ? S_I_NEXT : S_I_TAIL;
         end
         S_I_NEXT: begin
            if (cnt_ff == CNT_W'(I_CHUNKS - 1)) begin
               state_in = S_I_TAIL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_I_TAIL: state_in = S_SUM;
         S_SUM:    state_in = S_CLAMP;
         S_CLAMP:  state_in = S_OFS;
         S_OFS:    state_in = S_PEAK;
         S_PEAK: begin
            state_in = status.limit_hit ? S_MUL_LIN : S_FINISH;
         end
         S_MUL_LIN: state_in = S_MUL_ANG;
         S_MUL_ANG: state_in = S_DIV_LOAD;
         S_DIV_LOAD: begin
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = OP_LOAD;
            end
         end
         S_WRAP:     cmd.op = OP_WRAP;
         S_UPDATE:   cmd.op = OP_UPDATE;
         S_MUL_D:    cmd.op = OP_MUL_D;
         S_I_HEAD:   cmd.op = OP_I_HEAD;
         S_I_NEXT:   cmd.op = OP_I_NEXT;
         S_I_TAIL:   cmd.op = OP_I_TAIL;
         S_SUM:      cmd.op = OP_SUM;
         S_CLAMP:    cmd.op = OP_CLAMP;
         S_OFS:      cmd.op = OP_OFS;
         S_PEAK:     cmd.op = OP_PEAK;
         S_MUL_LIN:  cmd.op = OP_MUL_LIN;
         S_MUL_ANG:  cmd.op = OP_MUL_ANG;
         S_DIV_LOAD: cmd.op = OP_DIV_LOAD;
         S_DIV:      cmd.op = OP_DIV_STEP;
         S_FINISH: begin
            if (out_free) begin
               cmd.op   = OP_OUT;
               out_load = 1'b1;
            end
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* rtl/heading_pid_drive_controller_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_drive_controller_top
// Heading PID with angular clamp, speed selection and wheel speed limiting.
// ----------------------------------------------------------------------------
//  channel | ports          | payload (low bit first)
//  --------+----------------+-----------------------------------------------
//  request | req_t*         | tdata: robot_yaw, target_yaw
//          |                | tuser: target_valid, frontiers_present
//  result  | rsp_t*         | tdata: linear_velocity, angular_velocity,
//          |                |        wrapped_error, pad; tuser: wheel_limited
//  config  | csr_*          | csr_index, csr_data; always ready
//
//  A tick runs from accept through the yaw wrap loop, the integral partial
//  products on the shared 18x18 multiplier, the clamp and the speed steps to
//  the result; when the wheel limit applies, the serial divider pair runs
//  too. A stopped tick goes from its wrap step straight to the finish step.
//  Reset restores the register defaults and clears the error sum and the
//  last error. A new request is taken while a result waits in the output
//  register; a stalled result holds the next one in its finish step.
// ----------------------------------------------------------------------------
module heading_pid_drive_controller_top #(
   parameter int VALUE_WIDTH = hpdc_pkg::DEF_VALUE_WIDTH,
   parameter int SUM_WIDTH   = hpdc_pkg::DEF_SUM_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [hpdc_pkg::REQ_DATA_W-1:0]  req_tdata,  // robot_yaw, target_yaw
   input  logic [hpdc_pkg::REQ_USER_W-1:0]  req_tuser,  // target_valid, frontiers_present
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // linear_velocity, angular_velocity, wrapped_error, zero pad
   output logic [hpdc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [hpdc_pkg::RSP_USER_W-1:0]  rsp_tuser,  // wheel_limited
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hpdc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hpdc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import hpdc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PROP_GAIN:     cfg_in.prop_gain         = csr_data;
            CSR_INTEGRAL_GAIN: cfg_in.integral_gain     = csr_data;
            CSR_DERIV_GAIN:    cfg_in.deriv_gain        = csr_data;
            CSR_MAX_ANGULAR:   cfg_in.max_angular       = csr_data[SPEED_W-1:0];
            CSR_ALIGNED_THR:   cfg_in.aligned_threshold = csr_data[THRESH_W-1:0];
            CSR_ALIGNED_SPEED: cfg_in.aligned_speed     = csr_data[SPEED_W-1:0];
            CSR_TURNING_SPEED: cfg_in.turning_speed     = csr_data[SPEED_W-1:0];
            CSR_WHEEL_LIMIT:   cfg_in.wheel_speed_limit = csr_data[SPEED_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hpdc_ctrl #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   hpdc_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .SUM_WIDTH   (SUM_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .cfg       (cfg_ff),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

/* rtl/hpdc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpdc_checker
// Port-level checks for the heading PID drive controller.
// ----------------------------------------------------------------------------
module hpdc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [hpdc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [hpdc_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import hpdc_pkg::*;

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // output register is empty after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // one tick in flight: no request is taken in the cycle after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a tick is in flight");

   // forward speed is never negative
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[VEL_W-1])
      else $error("negative linear velocity");

endmodule

bind heading_pid_drive_controller_top hpdc_checker u_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the heading PID drive controller. A directed table
// of ticks (stop cases, yaw extremes, wrap edges at +-pi, speed threshold
// edges) is followed by phases of random ticks under several register
// settings and idle patterns. Every result transfer is compared with a
// tick-by-tick prediction of the heading error, PID sum, angular clamp,
// speed choice and wheel speed scaling.
// ----------------------------------------------------------------------------
module testbench;
   import hpdc_pkg::*;

   localparam int VAL_W       = DEF_VALUE_WIDTH;
   localparam int ACC_W       = DEF_SUM_WIDTH;
   localparam int QUIET_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 40;
   localparam int N_DIRECTED  = 19;

   typedef struct packed {
      logic signed [YAW_W-1:0] robot;
      logic signed [YAW_W-1:0] target;
      logic                    valid;
      logic                    frontiers;
   } tick_in_t;

   typedef struct packed {
      logic signed [VEL_W-1:0]  lin;
      logic signed [VEL_W-1:0]  ang;
      logic signed [WRAP_W-1:0] err;
      logic                     limited;
   } drive_cmd_t;

   typedef struct packed {
      tick_in_t   stim;
      logic       typed;
      drive_cmd_t want;
   } dir_row_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;   // robot_yaw, target_yaw
   logic [REQ_USER_W-1:0]   req_tuser = '0;   // target_valid, frontiers_present
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;        // linear, angular, wrapped_error, pad
   logic [RSP_USER_W-1:0]   rsp_tuser;        // wheel_limited
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   heading_pid_drive_controller_top #(
      .VALUE_WIDTH(VAL_W),
      .SUM_WIDTH  (ACC_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state and register copy
   cfg_type    gains = CFG_RESET;
   longint     err_sum = 0;
   longint     prev_err = 0;
   drive_cmd_t cmd_q[$];

   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_epoch = 0;
   int seen_epoch = 0;
   int hold_left = 0;
   int quiet = 0;

   function automatic longint clip(input longint v, input int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // one control tick: wrap, PID, clamp, speed pick, wheel limit
   function automatic drive_cmd_t steer_tick(input tick_in_t t);
      longint e, d, acc, a, lin, aa, ofs, peak, ae, lim_v;
      drive_cmd_t r;
      r = '0;
      if (!t.valid || !t.frontiers) return r;
      e = longint'(t.target) - longint'(t.robot);
      while (e > longint'(PI_Q12)) e -= longint'(TWO_PI_Q12);
      while (e <= -longint'(PI_Q12)) e += longint'(TWO_PI_Q12);
      err_sum  = clip(err_sum + e, ACC_W);
      d        = e - prev_err;
      prev_err = clip(e, VAL_W);
      acc = longint'(gains.prop_gain) * e + longint'(gains.deriv_gain) * d
          + ((longint'(gains.integral_gain) * err_sum) >>> FRAC_SHIFT);
      a = acc >>> FRAC_SHIFT;
      if (a > longint'(gains.max_angular)) a = longint'(gains.max_angular);
      if (a < -longint'(gains.max_angular)) a = -longint'(gains.max_angular);
      ae  = (e < 0) ? -e : e;
      lin = (ae < longint'(gains.aligned_threshold)) ? longint'(gains.aligned_speed)
                                                    : longint'(gains.turning_speed);
      aa    = (a < 0) ? -a : a;
      ofs   = (aa * longint'(HALF_TRACK_Q16) + 32768) >>> OFS_SHIFT;
      peak  = lin + ofs;
      lim_v = longint'(gains.wheel_speed_limit);
      if (lim_v != 0 && peak > lim_v) begin
         lin = lin * lim_v / peak;
         a   = a * lim_v / peak;   // truncates toward zero
         r.limited = 1'b1;
      end
      r.lin = lin[VEL_W-1:0];
      r.ang = a[VEL_W-1:0];
      r.err = e[WRAP_W-1:0];
      return r;
   endfunction

   // result side: check, then pick next tready
   always @(posedge clock) begin
      drive_cmd_t got, want;
      got = {rsp_tdata[VEL_W-1:0], rsp_tdata[2*VEL_W-1:VEL_W],
             rsp_tdata[2*VEL_W+WRAP_W-1:2*VEL_W], rsp_tuser[0]};
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cmd_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result lin %0d ang %0d err %0d lim %0d",
                        got.lin, got.ang, got.err, got.limited);
         end else begin
            want = cmd_q.pop_front();
            if (got.lin !== want.lin || got.ang !== want.ang ||
                got.err !== want.err || got.limited !== want.limited) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp lin %0d ang %0d err %0d lim %0d, got lin %0d ang %0d err %0d lim %0d",
                           want.lin, want.ang, want.err, want.limited,
                           got.lin, got.ang, got.err, got.limited);
            end
         end
      end
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_epoch != seen_epoch) begin
         seen_epoch <= hold_epoch;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value,
                            input int width);
      logic [CSR_DATA_W-1:0] junk;
      junk      = CSR_DATA_W'($urandom);
      csr_valid <= 1'b1;
      csr_index <= idx;
      // bits above the register width are don't-care
      csr_data  <= (width < CSR_DATA_W) ? ((junk << width) | CSR_DATA_W'(value)) : value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PROP_GAIN:     gains.prop_gain         = value;
         CSR_INTEGRAL_GAIN: gains.integral_gain     = value;
         CSR_DERIV_GAIN:    gains.deriv_gain        = value;
         CSR_MAX_ANGULAR:   gains.max_angular       = value[SPEED_W-1:0];
         CSR_ALIGNED_THR:   gains.aligned_threshold = value[THRESH_W-1:0];
         CSR_ALIGNED_SPEED: gains.aligned_speed     = value[SPEED_W-1:0];
         CSR_TURNING_SPEED: gains.turning_speed     = value[SPEED_W-1:0];
         CSR_WHEEL_LIMIT:   gains.wheel_speed_limit = value[SPEED_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input cfg_type c);
      write_reg(CSR_PROP_GAIN,     c.prop_gain,         GAIN_W);
      write_reg(CSR_INTEGRAL_GAIN, c.integral_gain,     GAIN_W);
      write_reg(CSR_DERIV_GAIN,    c.deriv_gain,        GAIN_W);
      write_reg(CSR_MAX_ANGULAR,   c.max_angular,       SPEED_W);
      write_reg(CSR_ALIGNED_THR,   c.aligned_threshold, THRESH_W);
      write_reg(CSR_ALIGNED_SPEED, c.aligned_speed,     SPEED_W);
      write_reg(CSR_TURNING_SPEED, c.turning_speed,     SPEED_W);
      write_reg(CSR_WHEEL_LIMIT,   c.wheel_speed_limit, SPEED_W);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering and wait out every pending result
   task automatic drain_ticks(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (cmd_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic offer_tick(input tick_in_t t, input logic typed, input drive_cmd_t want);
      int gap;
      drive_cmd_t pred;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t.target, t.robot};
      req_tuser  <= {t.frontiers, t.valid};
      do @(posedge clock); while (!req_tready);
      pred = steer_tick(t);
      cmd_q.push_back(typed ? want : pred);
   endtask

   function automatic tick_in_t random_tick();
      tick_in_t t;
      int k, span, off;
      logic [1:0] flags;
      t.robot     = YAW_W'($urandom);
      t.target    = YAW_W'($urandom);
      t.valid     = 1'b1;
      t.frontiers = 1'b1;
      k = $urandom_range(99);
      if (k < 8) begin
         flags = 2'($urandom_range(0, 2));   // at least one of the two low
         {t.frontiers, t.valid} = flags;
      end else if (k < 45) begin
         // full-range yaws
      end else if (k < 80) begin
         span     = int'(gains.aligned_threshold) + 16;
         off      = int'($urandom_range(0, 2 * span)) - span;
         t.target = t.robot + YAW_W'(off);
      end else begin
         case ($urandom_range(3))
            0: off = int'(PI_Q12);
            1: off = -int'(PI_Q12);
            2: off = int'(TWO_PI_Q12);
            default: off = -int'(TWO_PI_Q12);
         endcase
         off      = off + int'($urandom_range(0, 8)) - 4;
         t.target = t.robot + YAW_W'(off);
      end
      return t;
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.prop_gain         = GAIN_W'($urandom_range(0, 2048));
      c.integral_gain     = GAIN_W'($urandom);
      c.deriv_gain        = GAIN_W'($urandom_range(0, 4096));
      c.max_angular       = SPEED_W'($urandom);
      c.aligned_threshold = THRESH_W'($urandom_range(0, 12868));
      c.aligned_speed     = SPEED_W'($urandom);
      c.turning_speed     = SPEED_W'($urandom_range(0, 4096));
      c.wheel_speed_limit = ($urandom_range(3) == 0) ? '0 : SPEED_W'($urandom);
      return c;
   endfunction

   task automatic run_phase(input cfg_type c, input int n, input int sidle,
                            input int rstall, input logic hold);
      tick_in_t t;
      drain_ticks(SETTLE);
      program_regs(c);
      send_idle_pct  = sidle;
      recv_stall_pct = rstall;
      if (hold) hold_epoch <= hold_epoch + 1;
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) drain_ticks(0);
         t = random_tick();
         offer_tick(t, 1'b0, '0);
      end
   endtask

   // directed ticks; typed results only where obvious
   dir_row_t directed_rows [N_DIRECTED] = '{
      '{'{16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b1, '{16'sd1638, 16'sd0, 15'sd0, 1'b0}},
      '{'{16'sd1000, -16'sd1000, 1'b0, 1'b1}, 1'b1, '0},
      '{'{16'sd1000, -16'sd1000, 1'b1, 1'b0}, 1'b1, '0},
      '{'{16'sd32767, -16'sd32768, 1'b0, 1'b0}, 1'b1, '0},
      '{'{-16'sd32768, 16'sd32767, 1'b1, 1'b1}, 1'b0, '0},
      '{'{16'sd32767, -16'sd32768, 1'b1, 1'b1}, 1'b0, '0},
      // wrap edges: +pi stays, -pi flips to +pi, one past either side wraps
      '{'{16'sd0, 16'sd12868, 1'b1, 1'b1}, 1'b0, '0},
      '{'{16'sd12868, 16'sd0, 1'b1, 1'b1}, 1'b0, '0},
      '{'{16'sd0, 16'sd12869, 1'b1, 1'b1}, 1'b0, '0},
      '{'{16'sd12869, 16'sd0, 1'b1, 1'b1}, 1'b0, '0},
      // aligned threshold edges
      '{'{16'sd0, 16'sd1023, 1'b1, 1'b1}, 1'b0, '0},
      '{'{16'sd0, 16'sd1024, 1'b1, 1'b1}, 1'b0, '0},
      '{'{16'sd0, -16'sd1023, 1'b1, 1'b1}, 1'b0, '0},
      '{'{16'sd0, -16'sd1024, 1'b1, 1'b1}, 1'b0, '0},
      '{'{16'sd0, 16'sd10, 1'b1, 1'b1}, 1'b0, '0},
      '{'{-16'sd20000, 16'sd20000, 1'b1, 1'b1}, 1'b0, '0},
      '{'{-16'sd32768, -16'sd32768, 1'b1, 1'b1}, 1'b0, '0},
      '{'{16'sd0, -16'sd1, 1'b1, 1'b1}, 1'b0, '0},
      '{'{16'sd100, 16'sd100, 1'b1, 1'b1}, 1'b0, '0}
   };

   initial begin
      cfg_type c;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_tick(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

      run_phase(CFG_RESET, 250, 0, 0, 1'b0);

      c = '{prop_gain: 16'hFFFF, integral_gain: 16'hFFFF, deriv_gain: 16'hFFFF,
            max_angular: 15'h7FFF, aligned_threshold: 14'h3FFF,
            aligned_speed: 15'h7FFF, turning_speed: 15'h7FFF,
            wheel_speed_limit: 15'h7FFF};
      run_phase(c, 250, 51, 0, 1'b0);

      run_phase('0, 200, 0, 51, 1'b0);

      // limiting off, wide clamp
      c = CFG_RESET;
      c.max_angular       = 15'h7FFF;
      c.aligned_speed     = 15'h7FFF;
      c.wheel_speed_limit = '0;
      run_phase(c, 200, 16, 16, 1'b0);

      // tightest nonzero limit; receiver holds off while ticks keep coming
      c = CFG_RESET;
      c.wheel_speed_limit = 15'd1;
      c.max_angular       = 15'd12000;
      run_phase(c, 250, 0, 0, 1'b1);

      run_phase(random_cfg(), 200, 0, 0, 1'b0);
      run_phase(random_cfg(), 200, 51, 0, 1'b1);
      run_phase(random_cfg(), 200, 0, 51, 1'b0);
      run_phase(random_cfg(), 200, 16, 16, 1'b0);

      drain_ticks(SETTLE);
      if (mismatches == 0 && cmd_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
